### src/kpq_pkg.sv
// Shared types, constants and codes of the key press qualifier.
// No dependencies; every other file of the block takes names from here.
package kpq_pkg;

    localparam int KEY_BITS = 16;
    localparam int CODE_W = 16;
    localparam int COUNT_W = 16;
    localparam int CFG_W = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [CODE_W-1:0] KEY_MASK =
        CODE_W'((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd120;
    localparam logic [CFG_W-1:0] REPEAT_RESET = 16'd16;
    localparam logic [CFG_W-1:0] MIN_PRESS_RESET = 16'd2;
    localparam logic [CFG_W-1:0] RELEASE_RESET = 16'd2;

    typedef enum logic [1:0] {
        ACT_SCAN   = 2'd0,
        ACT_READ   = 2'd1,
        ACT_REPEAT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_LONG_PRESS = 2'd0,
        REG_REPEAT     = 2'd1,
        REG_MIN_PRESS  = 2'd2,
        REG_RELEASE    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] repeat_ticks;
        logic [CFG_W-1:0] min_press_ticks;
        logic [CFG_W-1:0] release_ticks;
    } cfg_t;

    typedef struct packed {
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
        logic              long_press;
    } result_t;

endpackage

### src/kpq_in_if.sv
// Input channel of the key press qualifier: action and scan code per item.
// Depends on kpq_pkg for field widths.
interface kpq_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [kpq_pkg::CODE_W-1:0] scan_code;

    modport source (output valid, output action, output scan_code, input ready);
    modport sink (input valid, input action, input scan_code, output ready);
endinterface

### src/kpq_out_if.sv
// Result channel of the key press qualifier: one item per read action.
// Depends on kpq_pkg for field widths.
interface kpq_out_if;
    logic                      valid;
    logic                      ready;
    logic                      key_valid;
    logic [kpq_pkg::CODE_W-1:0] key_code;
    logic                      long_press;

    modport source (output valid, output key_valid, output key_code, output long_press,
                    input ready);
    modport sink (input valid, input key_valid, input key_code, input long_press,
                  output ready);
endinterface

### src/kpq_core.sv
// Qualifier state and its single-pass update for one registered item.
// Depends on kpq_pkg for types, codes and counter limits.
module kpq_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  kpq_pkg::action_t           action,
    input  logic [kpq_pkg::CODE_W-1:0] code,
    input  kpq_pkg::cfg_t              cfg,
    output kpq_pkg::result_t           result
);

    logic [kpq_pkg::CODE_W-1:0]  previous_code_reg, previous_code_next;
    logic [kpq_pkg::COUNT_W-1:0] held_count_reg, held_count_next;
    logic [kpq_pkg::COUNT_W-1:0] released_count_reg, released_count_next;
    logic [kpq_pkg::CODE_W-1:0]  latched_code_reg, latched_code_next;
    logic                        latched_ready_reg, latched_ready_next;
    logic                        latched_long_reg, latched_long_next;
    logic                        repeat_mode_reg, repeat_mode_next;

    logic [kpq_pkg::COUNT_W-1:0] held_inc;
    logic [kpq_pkg::COUNT_W-1:0] released_inc;
    logic [kpq_pkg::CFG_W-1:0]   limit;
    logic                        same_code;
    logic                        code_nz;

    assign code_nz = (code != '0);
    assign same_code = (code == previous_code_reg);
    assign held_inc = (held_count_reg < kpq_pkg::COUNT_MAX) ?
                      held_count_reg + 1'b1 : held_count_reg;
    assign released_inc = (released_count_reg < kpq_pkg::COUNT_MAX) ?
                          released_count_reg + 1'b1 : released_count_reg;
    assign limit = repeat_mode_reg ? cfg.repeat_ticks : cfg.long_press_ticks;

    always_comb
    begin
        previous_code_next = previous_code_reg;
        held_count_next = held_count_reg;
        released_count_next = released_count_reg;
        latched_code_next = latched_code_reg;
        latched_ready_next = latched_ready_reg;
        latched_long_next = latched_long_reg;
        repeat_mode_next = repeat_mode_reg;
        if (fire)
        begin
            unique case (action)
                kpq_pkg::ACT_SCAN:
                begin
                    if (code_nz && previous_code_reg == '0)
                        latched_ready_next = 1'b0;
                    if (same_code && code_nz)
                    begin
                        released_count_next = '0;
                        latched_code_next = code;
                        held_count_next = held_inc;
                        if (held_inc == limit)
                        begin
                            latched_ready_next = 1'b1;
                            if (repeat_mode_reg)
                                held_count_next = '0;
                            else
                                latched_long_next = 1'b1;
                        end
                    end
                    else if (same_code)
                    begin
                        released_count_next = released_inc;
                        if (released_inc > cfg.release_ticks)
                        begin
                            if (held_count_reg > cfg.min_press_ticks &&
                                held_count_reg < cfg.long_press_ticks)
                            begin
                                latched_ready_next = 1'b1;
                                latched_long_next = 1'b0;
                            end
                            held_count_next = '0;
                            repeat_mode_next = 1'b0;
                        end
                    end
                    previous_code_next = code;
                end
                kpq_pkg::ACT_READ:
                    latched_ready_next = 1'b0;
                kpq_pkg::ACT_REPEAT:
                    repeat_mode_next = 1'b1;
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        result.key_valid = latched_ready_reg;
        result.key_code = latched_ready_reg ? latched_code_reg : '0;
        result.long_press = latched_ready_reg & latched_long_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_code_reg <= '0;
            held_count_reg <= '0;
            released_count_reg <= '0;
            latched_code_reg <= '0;
            latched_ready_reg <= 1'b0;
            latched_long_reg <= 1'b0;
            repeat_mode_reg <= 1'b0;
        end
        else
        begin
            previous_code_reg <= previous_code_next;
            held_count_reg <= held_count_next;
            released_count_reg <= released_count_next;
            latched_code_reg <= latched_code_next;
            latched_ready_reg <= latched_ready_next;
            latched_long_reg <= latched_long_next;
            repeat_mode_reg <= repeat_mode_next;
        end
    end

endmodule

### src/key_press_qualifier.sv
// Top level of the key press qualifier: APB registers, item registers, core.
// Depends on kpq_pkg, kpq_in_if, kpq_out_if and kpq_core.
//
// One item is taken per clock unless a held read waits on a full output
// register. An accepted item sits in the input register, then updates the
// qualifier state; a read action loads its result into the output register,
// where it holds until taken. The input register advances while the
// output register is empty or being taken, or when the held item is not a
// read. Registers at byte addresses 0, 4, 8, 12: long press ticks, repeat
// ticks, minimum press ticks, release ticks, 16 bits each, in pwdata[15:0].
module key_press_qualifier (
    input  logic                         clk,
    input  logic                         rst_n,
    kpq_in_if.sink                       scan,
    kpq_out_if.source                    key,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kpq_pkg::ADDR_W-1:0]   paddr,
    input  logic [kpq_pkg::DATA_W-1:0]   pwdata,
    output logic [kpq_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    kpq_pkg::cfg_t cfg_reg;
    kpq_pkg::reg_index_t reg_index;
    logic cfg_write;

    logic                       item_valid_reg;
    kpq_pkg::action_t           item_action_reg;
    logic [kpq_pkg::CODE_W-1:0] item_code_reg;
    logic                       item_advance;
    logic                       out_free;

    logic                       out_valid_reg;
    kpq_pkg::result_t           out_data_reg;
    kpq_pkg::result_t           core_result;

    assign pready = 1'b1;
    assign reg_index = kpq_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (reg_index)
            kpq_pkg::REG_LONG_PRESS: prdata = kpq_pkg::DATA_W'(cfg_reg.long_press_ticks);
            kpq_pkg::REG_REPEAT:     prdata = kpq_pkg::DATA_W'(cfg_reg.repeat_ticks);
            kpq_pkg::REG_MIN_PRESS:  prdata = kpq_pkg::DATA_W'(cfg_reg.min_press_ticks);
            kpq_pkg::REG_RELEASE:    prdata = kpq_pkg::DATA_W'(cfg_reg.release_ticks);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= kpq_pkg::LONG_PRESS_RESET;
            cfg_reg.repeat_ticks <= kpq_pkg::REPEAT_RESET;
            cfg_reg.min_press_ticks <= kpq_pkg::MIN_PRESS_RESET;
            cfg_reg.release_ticks <= kpq_pkg::RELEASE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                kpq_pkg::REG_LONG_PRESS: cfg_reg.long_press_ticks <= pwdata[15:0];
                kpq_pkg::REG_REPEAT:     cfg_reg.repeat_ticks <= pwdata[15:0];
                kpq_pkg::REG_MIN_PRESS:  cfg_reg.min_press_ticks <= pwdata[15:0];
                kpq_pkg::REG_RELEASE:    cfg_reg.release_ticks <= pwdata[15:0];
                default:                 ;
            endcase
        end
    end

    assign out_free = ~out_valid_reg | key.ready;
    assign item_advance = item_valid_reg &
                          ((item_action_reg != kpq_pkg::ACT_READ) | out_free);
    assign scan.ready = ~item_valid_reg | item_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (scan.ready)
            item_valid_reg <= scan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (scan.ready && scan.valid)
        begin
            item_action_reg <= kpq_pkg::action_t'(scan.action);
            item_code_reg <= scan.scan_code & kpq_pkg::KEY_MASK;
        end
    end

    kpq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (item_advance),
        .action (item_action_reg),
        .code   (item_code_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_advance && item_action_reg == kpq_pkg::ACT_READ)
            out_valid_reg <= 1'b1;
        else if (key.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_advance && item_action_reg == kpq_pkg::ACT_READ)
            out_data_reg <= core_result;
    end

    assign key.valid = out_valid_reg;
    assign key.key_valid = out_data_reg.key_valid;
    assign key.key_code = out_data_reg.key_code;
    assign key.long_press = out_data_reg.long_press;

endmodule

### verif/key_press_qualifier_tb.sv
// Self-checking testbench of key_press_qualifier: scan items in, read results out.
// Depends on kpq_pkg, kpq_in_if, kpq_out_if and the key_press_qualifier RTL.
// Mirrors the qualifier state at each accepted item; checks results in order.
module key_press_qualifier_tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int RUN_LIMIT_CYCLES = 800_000;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [kpq_pkg::ADDR_W-1:0] paddr;
    logic [kpq_pkg::DATA_W-1:0] pwdata;
    logic [kpq_pkg::DATA_W-1:0] prdata;
    logic pready;

    kpq_in_if scan_if ();
    kpq_out_if key_if ();

    key_press_qualifier i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan_if),
        .key     (key_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [kpq_pkg::CFG_W-1:0] cfg_long_ticks;
    logic [kpq_pkg::CFG_W-1:0] cfg_repeat_ticks;
    logic [kpq_pkg::CFG_W-1:0] cfg_min_ticks;
    logic [kpq_pkg::CFG_W-1:0] cfg_release_ticks;

    logic [kpq_pkg::CODE_W-1:0] last_code;
    logic [kpq_pkg::COUNT_W-1:0] hold_count;
    logic [kpq_pkg::COUNT_W-1:0] release_count;
    logic [kpq_pkg::CODE_W-1:0] key_latch;
    bit key_pending;
    bit key_is_long;
    bit auto_repeat;

    kpq_pkg::result_t expected_keys[$];
    int fail_count;
    int items_sent;
    bit idle_on;
    bit hold_off;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(8 * RUN_LIMIT_CYCLES);
        $display("key_press_qualifier verification failed");
        $finish;
    end

    task automatic qualify_item(input logic [1:0] act,
                                input logic [kpq_pkg::CODE_W-1:0] raw_code);
        logic [kpq_pkg::CODE_W-1:0] code;
        logic [kpq_pkg::COUNT_W-1:0] limit;
        kpq_pkg::result_t key_out;
        code = raw_code & kpq_pkg::KEY_MASK;
        case (act)
            kpq_pkg::ACT_SCAN:
            begin
                if (code != '0 && last_code == '0)
                    key_pending = 1'b0;
                if (code == last_code && code != '0)
                begin
                    limit = auto_repeat ? cfg_repeat_ticks : cfg_long_ticks;
                    release_count = '0;
                    if (hold_count < kpq_pkg::COUNT_MAX)
                        hold_count++;
                    key_latch = code;
                    if (hold_count == limit)
                    begin
                        key_pending = 1'b1;
                        if (auto_repeat)
                            hold_count = '0;
                        else
                            key_is_long = 1'b1;
                    end
                end
                else if (code == last_code)
                begin
                    if (release_count < kpq_pkg::COUNT_MAX)
                        release_count++;
                    if (release_count > cfg_release_ticks)
                    begin
                        if (hold_count > cfg_min_ticks && hold_count < cfg_long_ticks)
                        begin
                            key_pending = 1'b1;
                            key_is_long = 1'b0;
                        end
                        hold_count = '0;
                        auto_repeat = 1'b0;
                    end
                end
                last_code = code;
            end
            kpq_pkg::ACT_READ:
            begin
                key_out = '0;
                if (key_pending)
                begin
                    key_out.key_valid = 1'b1;
                    key_out.key_code = key_latch;
                    key_out.long_press = key_is_long;
                    key_pending = 1'b0;
                end
                expected_keys.push_back(key_out);
            end
            kpq_pkg::ACT_REPEAT:
                auto_repeat = 1'b1;
            default:
                ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && scan_if.valid && scan_if.ready)
            qualify_item(scan_if.action, scan_if.scan_code);
    end

    always @(posedge clk)
    begin
        kpq_pkg::result_t want;
        if (rst_n && key_if.valid && key_if.ready)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("unexpected key item: key_valid %b key_code %h long_press %b",
                       key_if.key_valid, key_if.key_code, key_if.long_press);
                fail_count++;
            end
            else
            begin
                want = expected_keys.pop_front();
                if (key_if.key_valid !== want.key_valid)
                begin
                    $error("key_valid: expected %b, actual %b", want.key_valid, key_if.key_valid);
                    fail_count++;
                end
                if (key_if.key_code !== want.key_code)
                begin
                    $error("key_code: expected %h, actual %h", want.key_code, key_if.key_code);
                    fail_count++;
                end
                if (key_if.long_press !== want.long_press)
                begin
                    $error("long_press: expected %b, actual %b",
                           want.long_press, key_if.long_press);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        key_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                key_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                key_if.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                key_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                key_if.ready <= 1'b1;
            end
            else
                key_if.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [kpq_pkg::CODE_W-1:0] code);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            scan_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        scan_if.valid <= 1'b1;
        scan_if.action <= act;
        scan_if.scan_code <= code;
        do
            @(posedge clk);
        while (!scan_if.ready);
        items_sent++;
    endtask

    task automatic wait_idle();
        scan_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input kpq_pkg::reg_index_t idx,
                             input logic [kpq_pkg::CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= kpq_pkg::ADDR_W'(idx) << 2;
        pwdata <= kpq_pkg::DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            kpq_pkg::REG_LONG_PRESS: cfg_long_ticks = value;
            kpq_pkg::REG_REPEAT:     cfg_repeat_ticks = value;
            kpq_pkg::REG_MIN_PRESS:  cfg_min_ticks = value;
            kpq_pkg::REG_RELEASE:    cfg_release_ticks = value;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [kpq_pkg::CFG_W-1:0] long_ticks,
                              input logic [kpq_pkg::CFG_W-1:0] repeat_ticks,
                              input logic [kpq_pkg::CFG_W-1:0] min_ticks,
                              input logic [kpq_pkg::CFG_W-1:0] release_ticks);
        wait_idle();
        write_reg(kpq_pkg::REG_LONG_PRESS, long_ticks);
        write_reg(kpq_pkg::REG_REPEAT, repeat_ticks);
        write_reg(kpq_pkg::REG_MIN_PRESS, min_ticks);
        write_reg(kpq_pkg::REG_RELEASE, release_ticks);
    endtask

    task automatic test_directed();
        send_item(kpq_pkg::ACT_READ, 16'h0000);
        send_item(ACT_UNUSED, 16'hFFFF);
        repeat (5) send_item(kpq_pkg::ACT_SCAN, 16'h0001);
        repeat (4) send_item(kpq_pkg::ACT_SCAN, 16'h0000);
        send_item(kpq_pkg::ACT_READ, 16'hFFFF);
        send_item(kpq_pkg::ACT_READ, 16'h0000);
        send_item(kpq_pkg::ACT_SCAN, 16'hFFFF);
        repeat (3) send_item(kpq_pkg::ACT_SCAN, 16'h00FF);
        send_item(kpq_pkg::ACT_REPEAT, 16'hFFFF);
        send_item(kpq_pkg::ACT_SCAN, 16'h00FF);
        repeat (4) send_item(kpq_pkg::ACT_SCAN, 16'h0000);
        send_item(kpq_pkg::ACT_READ, 16'h0000);
    endtask

    task automatic test_threshold_extremes();
        set_config(16'd1, 16'd1, 16'd0, 16'd0);
        repeat (3) send_item(kpq_pkg::ACT_SCAN, 16'hFFFF);
        send_item(kpq_pkg::ACT_READ, 16'h0000);
        send_item(kpq_pkg::ACT_REPEAT, 16'h0000);
        repeat (3) send_item(kpq_pkg::ACT_SCAN, 16'hFFFF);
        repeat (2) send_item(kpq_pkg::ACT_SCAN, 16'h0000);
        send_item(kpq_pkg::ACT_REPEAT, 16'h0000);
        send_item(kpq_pkg::ACT_SCAN, 16'h8000);
        repeat (2)
        begin
            repeat (2) send_item(kpq_pkg::ACT_SCAN, 16'h8000);
            send_item(kpq_pkg::ACT_READ, 16'h0000);
        end
        repeat (3) send_item(kpq_pkg::ACT_SCAN, 16'h0000);
        send_item(kpq_pkg::ACT_READ, 16'h0000);
        set_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        repeat (6) send_item(kpq_pkg::ACT_SCAN, 16'h1234);
        send_item(kpq_pkg::ACT_READ, 16'h0000);
        send_item(kpq_pkg::ACT_REPEAT, 16'h0000);
        repeat (4) send_item(kpq_pkg::ACT_SCAN, 16'h1234);
        repeat (3) send_item(kpq_pkg::ACT_SCAN, 16'h0000);
        send_item(kpq_pkg::ACT_READ, 16'h0000);
    endtask

    task automatic test_backpressure();
        int i;
        idle_on = 1'b1;
        set_config(16'd4, 16'd2, 16'd0, 16'd1);
        hold_off = 1'b1;
        send_item(kpq_pkg::ACT_SCAN, 16'h0040);
        send_item(kpq_pkg::ACT_REPEAT, 16'h0000);
        for (i = 0; i < 60; i++)
        begin
            if (i % 3 == 0)
                send_item(kpq_pkg::ACT_READ, 16'h0000);
            else
                send_item(kpq_pkg::ACT_SCAN, 16'h0040);
        end
        repeat (3) send_item(kpq_pkg::ACT_SCAN, 16'h0000);
        send_item(kpq_pkg::ACT_READ, 16'h0000);
        wait_idle();
    endtask

    task automatic run_random_phase(input int n_items);
        int start;
        int n;
        int k;
        logic [kpq_pkg::CODE_W-1:0] code;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                code = $urandom_range(0, 1) ? (16'd1 << $urandom_range(0, 15))
                                            : 16'($urandom);
                if (code == '0)
                    code = 16'h0001;
                send_item(kpq_pkg::ACT_SCAN, code);
                if ($urandom_range(0, 3) == 0)
                    send_item(kpq_pkg::ACT_REPEAT, 16'($urandom));
                n = $urandom_range(0, int'(cfg_long_ticks) + 3);
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(kpq_pkg::ACT_READ, 16'($urandom));
                    if ($urandom_range(0, 19) == 0)
                        send_item(kpq_pkg::ACT_REPEAT, 16'($urandom));
                    if ($urandom_range(0, 29) == 0)
                        code = code ^ 16'($urandom_range(1, 16'hFFFF));
                    send_item(kpq_pkg::ACT_SCAN, code);
                end
                n = $urandom_range(0, int'(cfg_release_ticks) + 3);
                repeat (n) send_item(kpq_pkg::ACT_SCAN, 16'h0000);
                if ($urandom_range(0, 3) != 0)
                    send_item(kpq_pkg::ACT_READ, 16'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(0, 3)), 16'($urandom));
            end
        end
    endtask

    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            set_config(16'($urandom_range(1, 24)), 16'($urandom_range(1, 6)),
                       16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
            idle_on = ($urandom_range(0, 3) != 0);
            run_random_phase(280);
        end
    endtask

    task automatic test_steady_stream();
        set_config(16'($urandom_range(2, 12)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)));
        idle_on = 1'b0;
        run_random_phase(200);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        scan_if.valid = 1'b0;
        scan_if.action = kpq_pkg::ACT_SCAN;
        scan_if.scan_code = '0;
        cfg_long_ticks = kpq_pkg::LONG_PRESS_RESET;
        cfg_repeat_ticks = kpq_pkg::REPEAT_RESET;
        cfg_min_ticks = kpq_pkg::MIN_PRESS_RESET;
        cfg_release_ticks = kpq_pkg::RELEASE_RESET;
        last_code = '0;
        hold_count = '0;
        release_count = '0;
        key_latch = '0;
        key_pending = 1'b0;
        key_is_long = 1'b0;
        auto_repeat = 1'b0;
        fail_count = 0;
        items_sent = 0;
        idle_on = 1'b1;
        hold_off = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_extremes();
        test_backpressure();
        test_random_phases();
        test_steady_stream();
        wait_idle();

        if (fail_count == 0)
            $display("key_press_qualifier verification clean");
        else
            $display("key_press_qualifier verification failed");
        $finish;
    end
endmodule

### sim.f
src/kpq_pkg.sv
src/kpq_in_if.sv
src/kpq_out_if.sv
src/kpq_core.sv
src/key_press_qualifier.sv
verif/key_press_qualifier_tb.sv
